// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame store and scan driver RTL.
// Every macro reports through $error and is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lmfs_pkg.sv =====
// Package for the LED matrix frame store and scan driver.
// Holds payload structs, opcode and state codes, widths and pixel packing helpers.
// No dependencies.
`default_nettype none

package lmfs_pkg;

  // Default geometry of the panel.
  localparam int DEF_PANEL_WIDTH = 64;
  localparam int DEF_SCAN_ROWS   = 32;

  // Fixed field widths.
  localparam int OPC_W     = 2;
  localparam int COORD_W   = 8;
  localparam int COLOR_W   = 6;
  localparam int WORD_W    = 6;
  localparam int RGB_W     = 3;
  localparam int ROWSEL_W  = 5;
  localparam int IVL_W     = 16;
  localparam int LOOP_W    = 12;
  localparam int OVH_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;

  // Register reset values.
  localparam logic [LOOP_W-1:0] LOOP_TIME_RST     = 12'd200;
  localparam logic [OVH_W-1:0]  CALL_OVERHEAD_RST = 10'd60;

  // Scan row reset value and the rows that set or clear the row bank bit.
  localparam logic [ROWSEL_W-1:0] SCAN_ROW_RST  = 5'd31;
  localparam logic [ROWSEL_W-1:0] ROW_BANK_SET  = 5'd16;
  localparam logic [ROWSEL_W-1:0] ROW_BANK_CLR  = 5'd0;

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_SWAP    = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_TIME     = 1'b0,
    CFG_CALL_OVERHEAD = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_LO,
    ST_P1_HI,
    ST_P1_CAP,
    ST_P2_LO,
    ST_P2_HI,
    ST_P2_CAP,
    ST_WR1_LO,
    ST_WR1_HI,
    ST_WR2_LO,
    ST_WR2_HI,
    ST_RD_OUT,
    ST_RF_RUN
  } st_e;

  typedef struct packed {
    logic [OPC_W-1:0]          opcode;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [COLOR_W-1:0]        pixel_color;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [COLOR_W-1:0]  read_color;
    logic [WORD_W-1:0]   shift_word;
    logic [ROWSEL_W-1:0] row_address;
    logic [IVL_W-1:0]    next_interval;
    logic                latch_pulse;
    logic                last;
  } out_item_t;

  // Enables of the frame store ports.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

  // Unpacks one pixel color from its low plane and high plane words.
  function automatic logic [COLOR_W-1:0] pix_get(logic [WORD_W-1:0] lo,
                                                 logic [WORD_W-1:0] hi,
                                                 logic upper);
    logic [COLOR_W-1:0] c;
    if (upper) begin
      c = {hi[WORD_W-1:RGB_W], lo[WORD_W-1:RGB_W]};
    end else begin
      c = {hi[RGB_W-1:0], lo[RGB_W-1:0]};
    end
    return c;
  endfunction

  // Replaces the three bits of one panel half in a plane word.
  function automatic logic [WORD_W-1:0] pix_put(logic [WORD_W-1:0] word,
                                                logic upper,
                                                logic [RGB_W-1:0] rgb);
    logic [WORD_W-1:0] w;
    if (upper) begin
      w = {rgb, word[RGB_W-1:0]};
    end else begin
      w = {word[WORD_W-1:RGB_W], rgb};
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/led_matrix_frame_store_bcm_scanner.sv =====
// Frame store and scan driver for an RGB LED panel with two bit planes.
// Input requests arrive on in_valid_i/in_stall_o, results leave on out_valid_o/out_stall_i;
// a request moves at a clock edge where valid is high and stall is low.
// Opcodes: write pixel (no result), read pixel (one result), swap two pixels (no result),
// refresh tick (PANEL_WIDTH shift words, first with latch_pulse, final one with last).
// All requests pass through the single read and single write port of the store;
// write and swap read each pixel's plane words and write them back, read waits for output.
// A refresh streams one shift word per cycle while the receiver keeps stall low;
// a stall holds the output register and pauses the store reads behind it.
// The next request is taken while a finished result still waits in the output register.
// loop_time and call_overhead are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user writes them only while the block is idle; the block does not enforce it.
// Reset clears the control state and the registers to 200 and 60, then sweeps the
// frame store to zero, one word per cycle, over all 2*SCAN_ROWS*PANEL_WIDTH words (4096
// by default). in_stall_o stays high during the sweep; configuration writes still land.
// Depends on lmfs_pkg, lmfs_store and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module led_matrix_frame_store_bcm_scanner #(
  parameter int PANEL_WIDTH = lmfs_pkg::DEF_PANEL_WIDTH,
  parameter int SCAN_ROWS   = lmfs_pkg::DEF_SCAN_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lmfs_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lmfs_pkg::out_item_t            out_item_o,
  input  logic                           cfg_we_i,
  input  logic [lmfs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lmfs_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import lmfs_pkg::*;

  localparam int DEPTH  = 2 * SCAN_ROWS * PANEL_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int ROW_W  = $clog2(SCAN_ROWS);
  localparam int CNT_W  = $clog2(PANEL_WIDTH + 1);
  localparam int CMP_W  = COORD_W + 1;
  localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(2 * PANEL_WIDTH);
  localparam logic [ADDR_W-1:0] PLANE_STRIDE = ADDR_W'(PANEL_WIDTH);

  typedef struct packed {
    logic              on;
    logic              up;
    logic [ADDR_W-1:0] addr;
  } pix_t;

  // Decodes a coordinate pair into panel membership, half and low plane address.
  function automatic pix_t pix_decode(logic signed [COORD_W-1:0] x,
                                      logic signed [COORD_W-1:0] y);
    pix_t              p;
    logic [CMP_W-1:0]  xe;
    logic [CMP_W-1:0]  ye;
    logic [ROW_W-1:0]  row;
    xe   = {1'b0, x};
    ye   = {1'b0, y};
    p.on = !x[COORD_W-1] && (xe < CMP_W'(PANEL_WIDTH)) &&
           !y[COORD_W-1] && (ye < CMP_W'(2 * SCAN_ROWS));
    p.up = (ye >= CMP_W'(SCAN_ROWS));
    if (p.up) begin
      row = ROW_W'(ye - CMP_W'(SCAN_ROWS));
    end else begin
      row = ROW_W'(ye);
    end
    p.addr = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(x[COL_W-1:0]);
    return p;
  endfunction

  st_e                 st_q, st_d;
  op_e                 op_q;
  logic [COLOR_W-1:0]  color_q;
  pix_t                p1_q, p2_q;
  logic [WORD_W-1:0]   lo1_q, lo1_d, hi1_q, hi1_d, lo2_q, lo2_d, hi2_q, hi2_d;
  logic                plane_q, plane_d;
  logic [ROWSEL_W-1:0] scan_row_q, scan_row_d;
  logic [ROWSEL_W-1:0] row_select_q, row_select_d;
  logic [IVL_W-1:0]    interval_q, interval_d;
  logic [LOOP_W-1:0]   loop_time_q, loop_time_d;
  logic [OVH_W-1:0]    call_overhead_q, call_overhead_d;
  logic [CNT_W-1:0]    iss_cnt_q, iss_cnt_d;
  logic                rd_valid_q, rd_valid_d;
  logic [COL_W-1:0]    rd_idx_q, rd_idx_d;
  out_item_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                in_accept;
  logic                out_free;
  logic                out_load;
  logic                rd_move;
  logic                rf_issue;
  store_ctl_t          st_ctl;
  logic [ADDR_W-1:0]   st_raddr, st_waddr;
  logic [WORD_W-1:0]   st_wdata, st_rdata;
  logic                st_busy;
  logic [ADDR_W-1:0]   rf_base;

  logic [COLOR_W-1:0]  c1, c2, wr_color1;
  logic [WORD_W-1:0]   new_lo1, new_hi1, base_lo2, base_hi2, new_lo2, new_hi2;
  logic                same_words;

  logic [LOOP_W:0]     iv_sum;
  logic [LOOP_W+1:0]   iv_shift;
  logic [IVL_W-1:0]    interval_nx;
  logic [ROWSEL_W:0]   scan_inc;
  logic                bank_bit;

  // Handshake of the two channels.
  assign in_stall_o  = (st_q != ST_IDLE) || st_busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Frame store with its clearing sweep.
  lmfs_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (st_ctl),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata),
    .busy_o  (st_busy)
  );

  // Configuration register writes.
  always_comb begin
    loop_time_d     = loop_time_q;
    call_overhead_d = call_overhead_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOOP_TIME:     loop_time_d     = cfg_data_i[LOOP_W-1:0];
        CFG_CALL_OVERHEAD: call_overhead_d = cfg_data_i[OVH_W-1:0];
        default: ;
      endcase
    end
  end

  // Display interval of the plane loaded by the previous tick.
  always_comb begin
    iv_sum      = (LOOP_W + 1)'(loop_time_q) + (LOOP_W + 1)'({call_overhead_q, 1'b0});
    iv_shift    = {1'b0, iv_sum} << plane_q;
    interval_nx = IVL_W'(iv_shift) - IVL_W'(call_overhead_q);
  end

  // Next scan row and row bank bit of a refresh tick.
  always_comb begin
    scan_inc = {1'b0, scan_row_q} + (ROWSEL_W + 1)'(1);
    bank_bit = row_select_q[ROWSEL_W-1];
    if (scan_row_q == ROW_BANK_SET) begin
      bank_bit = 1'b1;
    end else if (scan_row_q == ROW_BANK_CLR) begin
      bank_bit = 1'b0;
    end
  end

  // Pixel colors and merged plane words; the second pixel forwards the words
  // just written for the first pixel when both share a store word pair.
  always_comb begin
    c1         = p1_q.on ? pix_get(lo1_q, hi1_q, p1_q.up) : '0;
    c2         = p2_q.on ? pix_get(lo2_q, hi2_q, p2_q.up) : '0;
    wr_color1  = (op_q == OP_SWAP) ? c2 : color_q;
    new_lo1    = pix_put(lo1_q, p1_q.up, wr_color1[RGB_W-1:0]);
    new_hi1    = pix_put(hi1_q, p1_q.up, wr_color1[COLOR_W-1:RGB_W]);
    same_words = p1_q.on && (p1_q.addr == p2_q.addr);
    base_lo2   = same_words ? new_lo1 : lo2_q;
    base_hi2   = same_words ? new_hi1 : hi2_q;
    new_lo2    = pix_put(base_lo2, p2_q.up, c1[RGB_W-1:0]);
    new_hi2    = pix_put(base_hi2, p2_q.up, c1[COLOR_W-1:RGB_W]);
  end

  // Start of the row and plane being shifted out.
  assign rf_base = ADDR_W'(scan_row_q) * ROW_STRIDE + (plane_q ? PLANE_STRIDE : '0);

  // Refresh stream: one store read in flight, moved into the output register.
  assign rd_move  = (st_q == ST_RF_RUN) && rd_valid_q && out_free;
  assign rf_issue = (st_q == ST_RF_RUN) && (iss_cnt_q != CNT_W'(PANEL_WIDTH)) &&
                    (!rd_valid_q || rd_move);

  // Sequencer: next state, store accesses and result loading.
  always_comb begin
    st_d         = st_q;
    st_ctl       = '0;
    st_raddr     = p1_q.addr;
    st_waddr     = p1_q.addr;
    st_wdata     = new_lo1;
    lo1_d        = lo1_q;
    hi1_d        = hi1_q;
    lo2_d        = lo2_q;
    hi2_d        = hi2_q;
    plane_d      = plane_q;
    scan_row_d   = scan_row_q;
    row_select_d = row_select_q;
    interval_d   = interval_q;
    iss_cnt_d    = iss_cnt_q;
    rd_valid_d   = rd_valid_q;
    rd_idx_d     = rd_idx_q;
    out_load     = 1'b0;
    out_d        = out_q;

    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_item_i.opcode == OP_REFRESH) begin
            interval_d = interval_nx;
            if (plane_q) begin
              plane_d    = 1'b0;
              scan_row_d = (scan_inc >= (ROWSEL_W + 1)'(SCAN_ROWS)) ? '0 :
                           scan_inc[ROWSEL_W-1:0];
            end else begin
              plane_d      = 1'b1;
              row_select_d = {bank_bit, scan_row_q[ROWSEL_W-2:0]};
            end
            iss_cnt_d  = '0;
            rd_valid_d = 1'b0;
            st_d       = ST_RF_RUN;
          end else begin
            st_d = ST_P1_LO;
          end
        end
      end
      ST_P1_LO: begin
        st_ctl.rd_en = p1_q.on;
        st_raddr     = p1_q.addr;
        st_d         = ST_P1_HI;
      end
      ST_P1_HI: begin
        st_ctl.rd_en = p1_q.on;
        st_raddr     = p1_q.addr + PLANE_STRIDE;
        lo1_d        = st_rdata;
        st_d         = (op_q == OP_SWAP) ? ST_P2_LO : ST_P1_CAP;
      end
      ST_P1_CAP: begin
        hi1_d = st_rdata;
        st_d  = (op_q == OP_READ) ? ST_RD_OUT : ST_WR1_LO;
      end
      ST_P2_LO: begin
        st_ctl.rd_en = p2_q.on;
        st_raddr     = p2_q.addr;
        hi1_d        = st_rdata;
        st_d         = ST_P2_HI;
      end
      ST_P2_HI: begin
        st_ctl.rd_en = p2_q.on;
        st_raddr     = p2_q.addr + PLANE_STRIDE;
        lo2_d        = st_rdata;
        st_d         = ST_P2_CAP;
      end
      ST_P2_CAP: begin
        hi2_d = st_rdata;
        st_d  = ST_WR1_LO;
      end
      ST_WR1_LO: begin
        st_ctl.wr_en = p1_q.on;
        st_waddr     = p1_q.addr;
        st_wdata     = new_lo1;
        st_d         = ST_WR1_HI;
      end
      ST_WR1_HI: begin
        st_ctl.wr_en = p1_q.on;
        st_waddr     = p1_q.addr + PLANE_STRIDE;
        st_wdata     = new_hi1;
        st_d         = (op_q == OP_SWAP) ? ST_WR2_LO : ST_IDLE;
      end
      ST_WR2_LO: begin
        st_ctl.wr_en = p2_q.on;
        st_waddr     = p2_q.addr;
        st_wdata     = new_lo2;
        st_d         = ST_WR2_HI;
      end
      ST_WR2_HI: begin
        st_ctl.wr_en = p2_q.on;
        st_waddr     = p2_q.addr + PLANE_STRIDE;
        st_wdata     = new_hi2;
        st_d         = ST_IDLE;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_d.result_kind   = 1'b0;
          out_d.read_color    = c1;
          out_d.shift_word    = '0;
          out_d.row_address   = row_select_q;
          out_d.next_interval = '0;
          out_d.latch_pulse   = 1'b0;
          out_d.last          = 1'b1;
          st_d                = ST_IDLE;
        end
      end
      ST_RF_RUN: begin
        st_ctl.rd_en = rf_issue;
        st_raddr     = rf_base + ADDR_W'(iss_cnt_q[COL_W-1:0]);
        if (rf_issue) begin
          iss_cnt_d  = iss_cnt_q + CNT_W'(1);
          rd_idx_d   = iss_cnt_q[COL_W-1:0];
          rd_valid_d = 1'b1;
        end else if (rd_move) begin
          rd_valid_d = 1'b0;
        end
        if (rd_move) begin
          out_load            = 1'b1;
          out_d.result_kind   = 1'b1;
          out_d.read_color    = '0;
          out_d.shift_word    = st_rdata;
          out_d.row_address   = row_select_q;
          out_d.next_interval = interval_q;
          out_d.latch_pulse   = (rd_idx_q == '0);
          out_d.last          = (rd_idx_q == COL_W'(PANEL_WIDTH - 1));
          if (rd_idx_q == COL_W'(PANEL_WIDTH - 1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_IDLE;
      plane_q         <= 1'b1;
      scan_row_q      <= SCAN_ROW_RST;
      row_select_q    <= '0;
      loop_time_q     <= LOOP_TIME_RST;
      call_overhead_q <= CALL_OVERHEAD_RST;
      iss_cnt_q       <= '0;
      rd_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      st_q            <= st_d;
      plane_q         <= plane_d;
      scan_row_q      <= scan_row_d;
      row_select_q    <= row_select_d;
      loop_time_q     <= loop_time_d;
      call_overhead_q <= call_overhead_d;
      iss_cnt_q       <= iss_cnt_d;
      rd_valid_q      <= rd_valid_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Payload registers: request fields, captured words and the output item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_e'(in_item_i.opcode);
      color_q <= in_item_i.pixel_color;
      p1_q    <= pix_decode(in_item_i.first_x, in_item_i.first_y);
      p2_q    <= pix_decode(in_item_i.second_x, in_item_i.second_y);
    end
    lo1_q      <= lo1_d;
    hi1_q      <= hi1_d;
    lo2_q      <= lo2_d;
    hi2_q      <= hi2_d;
    interval_q <= interval_d;
    rd_idx_q   <= rd_idx_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // The sweep owns the store: no request port access while it runs.
  `ASSERT_SAME_CYCLE(a_store_idle_in_sweep, clk_i, rst_ni, st_busy,
                     !(st_ctl.wr_en || st_ctl.rd_en), "store accessed during clearing sweep")

  // A stalled result is never overwritten.
  `ASSERT_SAME_CYCLE(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i, !out_load,
                     "output register overwritten while stalled")

  // Only one refresh read is in flight at a time.
  `ASSERT_SAME_CYCLE(a_one_read_in_flight, clk_i, rst_ni, rd_valid_q && !rd_move, !rf_issue,
                     "refresh read issued over an unconsumed word")

  // Every refresh tick flips the bit plane.
  `ASSERT_NEXT_CYCLE(a_plane_flips, clk_i, rst_ni,
                     in_accept && (in_item_i.opcode == OP_REFRESH),
                     plane_q != $past(plane_q), "refresh tick did not advance the plane")

endmodule

`default_nettype wire

// ===== rtl/lmfs_store.sv =====
// Frame store memory: one write port, one registered read port, clearing sweep.
// Depends on lmfs_pkg for the word width and the port enable struct.
`default_nettype none

module lmfs_store #(
  parameter int DEPTH  = 2 * lmfs_pkg::DEF_SCAN_ROWS * lmfs_pkg::DEF_PANEL_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lmfs_pkg::store_ctl_t        ctl_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [lmfs_pkg::WORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [lmfs_pkg::WORD_W-1:0] rdata_o,
  output logic                        busy_o
);
  import lmfs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              busy_q, busy_d;

  // Clearing sweep after reset, one entry per cycle.
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    busy_d    = busy_q;
    if (busy_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      busy_q    <= 1'b1;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      busy_q    <= busy_d;
    end
  end

  // Memory array: the sweep owns the write port while it runs.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

`default_nettype wire
